### rtl/nfa_pkg.sv
// Shared types and constants for the NFA bit-set matcher.
package nfa_pkg;

  localparam int unsigned LabelW = 8;

  // NFA size: 64 states of two out-edge slots each, one table entry per slot.
  localparam int unsigned StateW = 6;
  localparam int unsigned StateCount = 64;
  localparam int unsigned SlotW = 1;
  localparam int unsigned EntryW = 7;
  localparam int unsigned EntryCount = 128;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_CHAR  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_OUT
  } state_t;

  localparam logic [1:0] CfgStart  = 2'd0;
  localparam logic [1:0] CfgAccept = 2'd1;

endpackage

### rtl/nfa_edge_mem.sv
// Edge table memory with a valid bit per entry and registered read data.
module nfa_edge_mem
  import nfa_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW = 7,
  parameter int unsigned SW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic                weps,
  input  logic [LabelW-1:0]   wlabel,
  input  logic [SW-1:0]       wtarget,
  input  logic                wpresent,
  input  logic [AW-1:0]       raddr,
  output logic                rpresent,
  output logic                reps,
  output logic [LabelW-1:0]   rlabel,
  output logic [SW-1:0]       rtarget
);

  logic [LabelW+SW:0] mem [DEPTH];
  logic [DEPTH-1:0]   present;
  logic [LabelW+SW:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      rpresent <= 1'b0;
    end else begin
      if (we) present[waddr] <= wpresent;
      rpresent <= present[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {weps, wlabel, wtarget};
    rdata <= mem[raddr];
  end

  assign reps    = rdata[LabelW+SW];
  assign rlabel  = rdata[LabelW+SW-1:SW];
  assign rtarget = rdata[SW-1:0];

endmodule

### rtl/nfa_bitset_matcher_top.sv
// Top level of the NFA bit-set matcher: sequencer, active-set registers and edge table.
// Edge writes and unused ops are taken straight from idle. A table pass reads all 128 entries
// through the single read port, then checks the result.
// A query stalls the input for p closure passes, a character for a labelled pass and p
// closure passes, plus a result state at string end; p is 1 to 64, twice for a first character.
// Synchronous reset clears every edge, both registers and the sequencer.
module nfa_bitset_matcher_top
  import nfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [5:0] edge_source,
  input  logic       edge_slot,
  input  logic       edge_present,
  input  logic       edge_is_epsilon,
  input  logic [7:0] edge_label,
  input  logic [5:0] edge_target,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched
);

  state_t state, state_next;
  logic [StateW-1:0] start_state, accept_state;
  logic [StateCount-1:0] active, work;
  logic [EntryW:0] scan_cnt;         // issued read address count
  logic rd_v;                        // read data valid this cycle
  logic [EntryW-1:0] rd_addr_q;      // address whose data is arriving
  logic eps_pass, grew, need_step, pending_end, is_start;
  logic [LabelW-1:0] cur_char;
  logic out_matched;
  logic out_valid_next;

  logic rpresent, reps;
  logic [LabelW-1:0] rlabel;
  logic [StateW-1:0] rtarget;
  logic [EntryW-1:0] raddr;
  logic wr_en;
  logic [EntryW-1:0] waddr;
  logic in_take, issue;
  logic src_live, hit, accept_hit;
  logic [StateW-1:0] src_state;

  // The block takes a request only while idle, so table writes never overlap a scan.
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Edge write address is source * 2 + slot. Every 6-bit source and 1-bit slot
  // names a real entry, so no write is dropped.
  assign waddr = {edge_source, edge_slot};
  assign wr_en = in_take && op == OP_EDGE;

  // A pass issues one read per cycle; the data returns in the cycle after.
  assign issue = (state == ST_SCAN) && (scan_cnt < (EntryW+1)'(EntryCount));
  assign raddr = scan_cnt[EntryW-1:0];

  nfa_edge_mem #(.DEPTH(EntryCount), .AW(EntryW), .SW(StateW)) u_mem (
    .clk, .rst, .we(wr_en), .waddr, .weps(edge_is_epsilon), .wlabel(edge_label),
    .wtarget(edge_target), .wpresent(edge_present), .raddr,
    .rpresent, .reps, .rlabel, .rtarget
  );

  function automatic logic [StateCount-1:0] onehot_of(input logic [StateW-1:0] s);
    logic [StateCount-1:0] v;
    v = '0;
    v[s] = 1'b1;
    return v;
  endfunction

  // An epsilon pass closes the working set in place; a labelled pass reads the
  // old active set and collects the targets of edges that consume the character.
  // Updating the set in place during a closure pass only speeds up convergence.
  always_comb begin
    src_state = rd_addr_q[EntryW-1:SlotW];
    src_live = eps_pass ? work[src_state] : active[src_state];
    hit = rd_v && rpresent && src_live &&
          (eps_pass ? reps : (!reps && rlabel == cur_char));
  end

  assign accept_hit = work[accept_state];

  // The result register parts the output from the sequencer: the block can go
  // back to idle while a result still waits to be taken.
  always_comb begin
    state_next = state;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    unique case (state)
      ST_IDLE: if (in_take && (op == OP_CHAR || op == OP_QUERY)) state_next = ST_SCAN;
      ST_SCAN: if (!issue && !rd_v) state_next = ST_CHECK;
      ST_CHECK: begin
        // Another pass follows a labelled pass, a growing closure pass, or the
        // start closure that precedes the first character of a string.
        if (!eps_pass || grew || need_step) state_next = ST_SCAN;
        else if (pending_end) state_next = ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start_state <= '0;
      accept_state <= '0;
      is_start <= 1'b1;
      scan_cnt <= '0;
      rd_v <= 1'b0;
      out_valid <= 1'b0;
      out_matched <= 1'b0;
      eps_pass <= 1'b0;
      grew <= 1'b0;
      need_step <= 1'b0;
      pending_end <= 1'b0;
      cur_char <= '0;
      work <= '0;
      active <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      rd_v <= issue;
      rd_addr_q <= raddr;
      if (cfg_we && cfg_index == CfgStart[0:0]) start_state <= cfg_data;
      if (cfg_we && cfg_index == CfgAccept[0:0]) accept_state <= cfg_data;
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            scan_cnt <= '0;
            grew <= 1'b0;
            unique case (op)
              OP_CHAR: begin
                cur_char <= char_byte;
                pending_end <= last_char;
                is_start <= 1'b0;
                if (is_start) begin
                  // First character: build the start closure, then step.
                  work <= onehot_of(start_state);
                  eps_pass <= 1'b1;
                  need_step <= 1'b1;
                end else begin
                  work <= '0;
                  eps_pass <= 1'b0;
                  need_step <= 1'b0;
                end
              end
              OP_QUERY: begin
                // An empty string abandons any partial string.
                work <= onehot_of(start_state);
                eps_pass <= 1'b1;
                need_step <= 1'b0;
                pending_end <= 1'b1;
                is_start <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) scan_cnt <= scan_cnt + 1'b1;
          if (hit) begin
            work[rtarget] <= 1'b1;
            if (eps_pass && !work[rtarget]) grew <= 1'b1;
          end
        end
        ST_CHECK: begin
          scan_cnt <= '0;
          grew <= 1'b0;
          if (!eps_pass) begin
            // Labelled step done: close the new set over epsilon edges.
            eps_pass <= 1'b1;
          end else if (!grew) begin
            active <= work;
            if (need_step) begin
              // Start closure done: now apply the labelled step.
              work <= '0;
              eps_pass <= 1'b0;
              need_step <= 1'b0;
            end else if (pending_end) begin
              is_start <= 1'b1;
            end
          end
        end
        ST_OUT: if (!out_valid || !out_stall) out_matched <= accept_hit;
        default: ;
      endcase
    end
  end

  assign matched = out_matched;

endmodule

### rtl/nfa_checker.sv
// Port-level checker for the NFA bit-set matcher.
module nfa_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic matched
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched)) else $error("result dropped");
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(matched)) else $error("unknown result");
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall) else $error("not ready after reset");

endmodule

bind nfa_bitset_matcher_top nfa_checker u_chk (.*);

### tb/nfa_bitset_matcher_checker.sv
// Checker for the NFA bit-set matcher: watches both channels and predicts match results.
module nfa_bitset_matcher_checker
  import nfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] op,
  input  logic [5:0] edge_source,
  input  logic       edge_slot,
  input  logic       edge_present,
  input  logic       edge_is_epsilon,
  input  logic [7:0] edge_label,
  input  logic [5:0] edge_target,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       matched,
  output int         fail_count,
  output int         pending_matches
);

  localparam int NStates = 64;
  localparam int NSlots = 2;

  // Entry layout: present, epsilon, label, target.
  typedef struct packed {
    logic       present;
    logic       eps;
    logic [7:0] label;
    logic [5:0] target;
  } edge_entry_t;

  edge_entry_t edges_m [NStates*NSlots];
  logic [63:0] live_states;
  logic        string_fresh;
  logic [5:0]  start_m, accept_m;
  logic        match_q [$];

  assign pending_matches = match_q.size();

  function automatic logic [63:0] close_eps(input logic [63:0] s);
    logic [63:0] cur;
    logic grew;
    edge_entry_t e;
    cur = s;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int st = 0; st < NStates; st++) begin
        if (cur[st]) begin
          for (int k = 0; k < NSlots; k++) begin
            e = edges_m[st*NSlots + k];
            if (e.present && e.eps && !cur[e.target]) begin
              cur[e.target] = 1'b1;
              grew = 1'b1;
            end
          end
        end
      end
    end
    return cur;
  endfunction

  function automatic logic [63:0] start_closure();
    logic [63:0] s;
    s = '0;
    s[start_m] = 1'b1;
    return close_eps(s);
  endfunction

  function automatic logic [63:0] advance_on(input logic [63:0] s, input logic [7:0] c);
    logic [63:0] nxt;
    edge_entry_t e;
    nxt = '0;
    for (int st = 0; st < NStates; st++) begin
      if (s[st]) begin
        for (int k = 0; k < NSlots; k++) begin
          e = edges_m[st*NSlots + k];
          if (e.present && !e.eps && e.label == c) nxt[e.target] = 1'b1;
        end
      end
    end
    return close_eps(nxt);
  endfunction

  always @(posedge clk) begin
    logic got;
    logic [63:0] query_set;
    if (rst) begin
      for (int i = 0; i < NStates*NSlots; i++) edges_m[i] <= '0;
      start_m <= '0;
      accept_m <= '0;
      string_fresh <= 1'b1;
      fail_count <= 0;
      match_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgStart[0:0]) start_m <= cfg_data;
        else if (cfg_index == CfgAccept[0:0]) accept_m <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        case (op_t'(op))
          OP_EDGE: begin
            edges_m[edge_source*NSlots + edge_slot] <= edge_present ?
                {1'b1, edge_is_epsilon, edge_label, edge_target} : '0;
          end
          OP_CHAR: begin
            live_states = advance_on(string_fresh ? start_closure() : live_states,
                                     char_byte);
            string_fresh <= last_char;
            if (last_char) match_q.push_back(live_states[accept_m]);
          end
          OP_QUERY: begin
            string_fresh <= 1'b1;
            query_set = start_closure();
            match_q.push_back(query_set[accept_m]);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected match result %b", $time, matched);
          fail_count <= fail_count + 1;
        end else begin
          got = match_q.pop_front();
          if (got !== matched) begin
            $display("%0t: matched mismatch: expected %b, actual %b", $time, got, matched);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_nfa_bitset_matcher_top.sv
// Testbench top for the NFA bit-set matcher: stimulus, handshake pacing and verdict.
module tb_nfa_bitset_matcher_top;
  import nfa_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = OP_NONE;
  logic [5:0] edge_source = '0;
  logic       edge_slot = 1'b0;
  logic       edge_present = 1'b0;
  logic       edge_is_epsilon = 1'b0;
  logic [7:0] edge_label = '0;
  logic [5:0] edge_target = '0;
  logic [7:0] char_byte = '0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       matched;
  int         fail_count;
  int         pending_matches;

  // Requests left in the current burst, and whether valid is still held high.
  int burst_left = 0;
  bit held = 1'b0;

  always #2 clk = ~clk;

  nfa_bitset_matcher_top u_top (.*);

  nfa_bitset_matcher_checker u_chk (.*);

  // The receiver stalls on a slowly changing random pattern, sometimes not at all.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // End a burst: drop valid and idle for a random number of cycles.
  task automatic drop_input();
    if (held) begin
      in_valid <= 1'b0;
      held = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Present one request and hold it until the block takes it. Within a burst
  // the next request follows on the cycle right after the accepting edge.
  task automatic send_request(input op_t o, input logic [5:0] src, input logic slot,
                              input logic pres, input logic eps, input logic [7:0] lbl,
                              input logic [5:0] tgt, input logic [7:0] ch,
                              input logic last);
    if (!held) burst_left = $urandom_range(1, 12);
    op <= o;
    edge_source <= src;
    edge_slot <= slot;
    edge_present <= pres;
    edge_is_epsilon <= eps;
    edge_label <= lbl;
    edge_target <= tgt;
    char_byte <= ch;
    last_char <= last;
    in_valid <= 1'b1;
    held = 1'b1;
    while (in_stall) @(negedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) drop_input();
  endtask

  task automatic put_edge(input logic [5:0] src, input logic slot, input logic pres,
                          input logic eps, input logic [7:0] lbl, input logic [5:0] tgt);
    send_request(OP_EDGE, src, slot, pres, eps, lbl, tgt, 8'($urandom), 1'($urandom));
  endtask

  task automatic put_char(input logic [7:0] ch, input logic last);
    send_request(OP_CHAR, 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                 8'($urandom), 6'($urandom), ch, last);
  endtask

  // Register writes happen only with the block idle and no result outstanding.
  task automatic write_reg(input logic [0:0] idx, input logic [5:0] val);
    drop_input();
    while (in_stall || pending_matches != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A random small automaton lives in states base..base+7, so that strings
  // over a tiny alphabet reach the accept state often.
  task automatic random_phase(input int n_items, input logic [5:0] base);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        put_edge(base + 6'($urandom_range(0, 7)), 1'($urandom),
                 $urandom_range(0, 7) != 0, $urandom_range(0, 2) == 0,
                 8'h60 + 8'($urandom_range(0, 3)), base + 6'($urandom_range(0, 7)));
      end else if (r < 23) begin
        put_edge(6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                 6'($urandom));
      end else if (r < 85) begin
        put_char(8'h60 + 8'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      end else if (r < 90) begin
        put_char(8'($urandom), 1'($urandom));
      end else if (r < 97) begin
        send_request(OP_QUERY, 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                     8'($urandom), 6'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_request(OP_NONE, 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                     8'($urandom), 6'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part. An empty table with start equal to accept matches the
    // empty string; any character then leaves the set empty.
    send_request(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0);
    put_char(8'h00, 1'b1);
    // Chain 0 -a-> 1 -eps-> 63, with the label at both byte extremes.
    put_edge(6'd0, 1'b0, 1'b1, 1'b0, 8'hFF, 6'd1);
    put_edge(6'd0, 1'b1, 1'b1, 1'b0, 8'h00, 6'd62);
    put_edge(6'd1, 1'b1, 1'b1, 1'b1, 8'hAA, 6'd63);
    put_edge(6'd63, 1'b0, 1'b1, 1'b1, 8'h55, 6'd0);
    write_reg(CfgAccept[0:0], 6'd63);
    put_char(8'hFF, 1'b1);
    put_char(8'h00, 1'b1);
    // Byte zero mid-string, then an abandoned string cut off by a query.
    put_char(8'h00, 1'b0);
    send_request(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0);
    put_char(8'hFF, 1'b0);
    put_char(8'hFF, 1'b1);
    // Removing an edge mid-string, and an ignored op.
    put_char(8'hFF, 1'b0);
    put_edge(6'd63, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0);
    send_request(OP_NONE, 6'h3F, 1'b1, 1'b1, 1'b1, 8'hFF, 6'h3F, 8'hFF, 1'b1);
    put_char(8'hFF, 1'b1);
    write_reg(CfgStart[0:0], 6'd63);
    send_request(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0);
    put_char(8'h55, 1'b1);

    // Random phases across several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      logic [5:0] base;
      base = (ph == 5) ? 6'd56 : 6'($urandom_range(0, 56));
      write_reg(CfgStart[0:0], (ph == 0) ? 6'd0 : base + 6'($urandom_range(0, 7)));
      write_reg(CfgAccept[0:0], (ph == 5) ? 6'd63 : base + 6'($urandom_range(0, 7)));
      random_phase(150, base);
    end

    drop_input();
    while (in_stall || pending_matches != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Worst case per item is the longest closure run plus stalls; allow several
  // times that for every request.
  initial begin
    #300000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
